// ===== rtl/lip_pkg.sv =====
package lip_pkg;

    localparam int VECTOR_COUNT_DEF = 256;
    localparam int WORD_BITS_DEF    = 64;

    localparam int          APB_ADDR_W    = 3;
    localparam int          APB_DATA_W    = 32;
    localparam logic [7:0]  SPURIOUS_RST  = 8'hFF;
    localparam logic [7:0]  CLASS_MASK    = 8'hF0;

    typedef enum logic [2:0] {
        MODE_DELIVER = 3'd0,
        MODE_EOI     = 3'd1,
        MODE_ACK     = 3'd2,
        MODE_SET_TPR = 3'd3,
        MODE_QUERY   = 3'd4
    } t_mode;

    typedef enum logic {
        REG_ENABLE   = 1'b0,
        REG_SPURIOUS = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       enable;
        logic [7:0] spurious;
    } t_cfg;

    typedef struct packed {
        logic       clear;
        logic       load;
        logic       dlv_upd;
        logic [7:0] dlv_vec;
    } t_scan_ctl;

    typedef struct packed {
        logic       hr_found;
        logic [7:0] hr;
        logic       hs_found;
        logic [7:0] hs;
    } t_summary;

    // highest request can be taken by an acknowledge
    function automatic logic deliverable(input t_summary s, input logic [7:0] tpr);
        logic ok;
        ok = s.hr_found;
        if (s.hs_found && (s.hs >= s.hr)) begin
            ok = 1'b0;
        end
        if ((s.hr & CLASS_MASK) <= (tpr & CLASS_MASK)) begin
            ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

// ===== rtl/local_interrupt_prioritizer.sv =====
// Local interrupt prioritizer: request, in-service and level bitmaps live in
// one single-port-write RAM, one row per word, with a cached summary of the
// highest request and highest in-service vector. A command is taken when
// start is high and busy is low; its one result shows on the o_ ports for a
// single cycle with o_valid and cannot be held off. Set task priority, query
// and dropped deliveries go straight to the result, an accepted delivery
// reads and writes back one row, and acknowledge or end of interrupt that
// change the bitmaps also rescan every row through the RAM read port to
// rebuild the summary. Rows are marked valid in flip-flops, so no clearing
// pass follows reset.
module local_interrupt_prioritizer #(
    parameter int VECTOR_COUNT = lip_pkg::VECTOR_COUNT_DEF,
    parameter int WORD_BITS    = lip_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_mode,
    input  logic [7:0]                      i_vector,
    input  logic                            i_level_triggered,
    input  logic                            i_masked,
    input  logic [7:0]                      i_priority_value,
    output logic                            o_valid,
    output logic [7:0]                      o_ack_vector,
    output logic                            o_pending,
    output logic                            o_remote_eoi,
    output logic [7:0]                      o_remote_eoi_vector,
    output logic [7:0]                      o_highest_in_service,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lip_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lip_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lip_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int NWORDS = (VECTOR_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int RAM_W  = 3 * WORD_BITS;

    lip_pkg::t_cfg      cfg;
    lip_pkg::t_summary  sum;
    lip_pkg::t_scan_ctl scan_ctl;
    lip_pkg::t_state    r_state, n_state;

    logic [2:0]         r_mode, n_mode;
    logic [7:0]         r_vec, n_vec;
    logic               r_lvl, n_lvl;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [7:0]         r_tpr, n_tpr;
    logic [7:0]         r_ack, n_ack;
    logic               r_reoi, n_reoi;
    logic [7:0]         r_reoi_vec, n_reoi_vec;
    logic [ROW_W-1:0]   r_cnt, n_cnt;
    logic               r_scan_pend, n_scan_pend;
    logic [ROW_W-1:0]   r_scan_row, n_scan_row;
    logic [NWORDS-1:0]  r_row_vld, n_row_vld;
    logic               r_rd_vld;

    logic               r_o_valid, n_o_valid;
    logic [7:0]         r_o_ack, n_o_ack;
    logic               r_o_pending, n_o_pending;
    logic               r_o_reoi, n_o_reoi;
    logic [7:0]         r_o_reoi_vec, n_o_reoi_vec;
    logic [7:0]         r_o_his, n_o_his;

    logic               ram_we;
    logic [ROW_W-1:0]   ram_raddr;
    logic [RAM_W-1:0]   ram_wdata;
    logic [RAM_W-1:0]   ram_rdata;
    logic [RAM_W-1:0]   rd_row;
    logic [WORD_BITS-1:0] rd_req, rd_isv, rd_lvl;

    lip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lip_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NWORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // rows never written read as zero
    assign rd_row = ram_rdata & {RAM_W{r_rd_vld}};
    assign rd_req = rd_row[WORD_BITS-1:0];
    assign rd_isv = rd_row[2*WORD_BITS-1:WORD_BITS];
    assign rd_lvl = rd_row[3*WORD_BITS-1:2*WORD_BITS];

    lip_scan #(
        .VECTOR_COUNT (VECTOR_COUNT),
        .WORD_BITS    (WORD_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_row      (r_scan_row),
        .i_req_word (rd_req),
        .i_isv_word (rd_isv),
        .o_sum      (sum)
    );

    assign ram_raddr = (r_state == lip_pkg::ST_SCAN) ? r_cnt : r_row;
    assign busy      = (r_state != lip_pkg::ST_IDLE);

    always_comb begin
        logic [7:0]           sel_vec;
        logic [ROW_W-1:0]     sel_row;
        logic [BIT_W-1:0]     sel_bit;
        logic                 in_range;
        logic [WORD_BITS-1:0] bmask;
        logic [WORD_BITS-1:0] w_req, w_isv, w_lvl;

        n_state      = r_state;
        n_mode       = r_mode;
        n_vec        = r_vec;
        n_lvl        = r_lvl;
        n_row        = r_row;
        n_bit        = r_bit;
        n_tpr        = r_tpr;
        n_ack        = r_ack;
        n_reoi       = r_reoi;
        n_reoi_vec   = r_reoi_vec;
        n_cnt        = r_cnt;
        n_scan_pend  = 1'b0;
        n_scan_row   = r_scan_row;
        n_row_vld    = r_row_vld;
        n_o_valid    = 1'b0;
        n_o_ack      = r_o_ack;
        n_o_pending  = r_o_pending;
        n_o_reoi     = r_o_reoi;
        n_o_reoi_vec = r_o_reoi_vec;
        n_o_his      = r_o_his;
        ram_we       = 1'b0;
        scan_ctl     = '0;

        // vector picked at accept time: delivered, highest in service or highest request
        sel_vec = i_vector;
        if (i_mode == lip_pkg::MODE_EOI) begin
            sel_vec = sum.hs;
        end else if (i_mode == lip_pkg::MODE_ACK) begin
            sel_vec = sum.hr;
        end
        sel_row = '0;
        sel_bit = '0;
        for (int r = 0; r < NWORDS; r++) begin
            if ({1'b0, sel_vec} >= 9'(r * WORD_BITS)) begin
                sel_row = ROW_W'(r);
                sel_bit = BIT_W'(int'(sel_vec) - r * WORD_BITS);
            end
        end
        in_range = ({1'b0, i_vector} < 9'(VECTOR_COUNT));

        bmask = '0;
        bmask[r_bit] = 1'b1;
        w_req = rd_req;
        w_isv = rd_isv;
        w_lvl = rd_lvl;
        ram_wdata = {w_lvl, w_isv, w_req};

        unique case (r_state)
            lip_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode     = i_mode;
                    n_vec      = sel_vec;
                    n_lvl      = i_level_triggered;
                    n_row      = sel_row;
                    n_bit      = sel_bit;
                    n_ack      = '0;
                    n_reoi     = 1'b0;
                    n_reoi_vec = '0;
                    n_state    = lip_pkg::ST_FINISH;
                    unique case (i_mode)
                        lip_pkg::MODE_DELIVER: begin
                            if (!cfg.enable) begin
                                n_reoi     = 1'b1;
                                n_reoi_vec = i_vector;
                            end else if (!i_masked && in_range) begin
                                n_state = lip_pkg::ST_READ;
                            end
                        end
                        lip_pkg::MODE_EOI: begin
                            if (sum.hs_found) begin
                                n_state = lip_pkg::ST_READ;
                            end
                        end
                        lip_pkg::MODE_ACK: begin
                            if (lip_pkg::deliverable(sum, r_tpr)) begin
                                n_ack   = sum.hr;
                                n_state = lip_pkg::ST_READ;
                            end else begin
                                n_ack = cfg.spurious;
                            end
                        end
                        lip_pkg::MODE_SET_TPR: begin
                            n_tpr = i_priority_value;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            lip_pkg::ST_READ: begin
                n_state = lip_pkg::ST_MODIFY;
            end
            lip_pkg::ST_MODIFY: begin
                ram_we           = 1'b1;
                n_row_vld[r_row] = 1'b1;
                n_cnt            = ROW_W'(NWORDS - 1);
                unique case (r_mode)
                    lip_pkg::MODE_DELIVER: begin
                        w_req = rd_req | bmask;
                        w_lvl = r_lvl ? (rd_lvl | bmask) : (rd_lvl & ~bmask);
                        scan_ctl.dlv_upd = 1'b1;
                        scan_ctl.dlv_vec = r_vec;
                        n_state = lip_pkg::ST_FINISH;
                    end
                    lip_pkg::MODE_EOI: begin
                        w_isv          = rd_isv & ~bmask;
                        n_reoi         = rd_lvl[r_bit];
                        n_reoi_vec     = rd_lvl[r_bit] ? r_vec : 8'd0;
                        scan_ctl.clear = 1'b1;
                        n_state        = lip_pkg::ST_SCAN;
                    end
                    lip_pkg::MODE_ACK: begin
                        w_req          = rd_req & ~bmask;
                        w_isv          = rd_isv | bmask;
                        scan_ctl.clear = 1'b1;
                        n_state        = lip_pkg::ST_SCAN;
                    end
                    default: begin
                        ram_we           = 1'b0;
                        n_row_vld[r_row] = r_row_vld[r_row];
                        n_state          = lip_pkg::ST_FINISH;
                    end
                endcase
                ram_wdata = {w_lvl, w_isv, w_req};
            end
            lip_pkg::ST_SCAN: begin
                // one row read per cycle, top row first; read data is folded in once the RAM has registered it
                scan_ctl.load = r_scan_pend;
                n_scan_pend   = 1'b1;
                n_scan_row    = r_cnt;
                if (r_cnt == '0) begin
                    n_state = lip_pkg::ST_DRAIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            lip_pkg::ST_DRAIN: begin
                scan_ctl.load = r_scan_pend;
                n_state       = lip_pkg::ST_FINISH;
            end
            lip_pkg::ST_FINISH: begin
                n_o_valid    = 1'b1;
                n_o_ack      = r_ack;
                n_o_pending  = cfg.enable && lip_pkg::deliverable(sum, r_tpr);
                n_o_reoi     = r_reoi;
                n_o_reoi_vec = r_reoi_vec;
                n_o_his      = sum.hs_found ? sum.hs : r_tpr;
                n_state      = lip_pkg::ST_IDLE;
            end
            default: begin
                n_state = lip_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lip_pkg::ST_IDLE;
            r_tpr       <= '0;
            r_row_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_scan_pend <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tpr       <= n_tpr;
            r_row_vld   <= n_row_vld;
            r_rd_vld    <= r_row_vld[ram_raddr];
            r_scan_pend <= n_scan_pend;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_vec        <= n_vec;
        r_lvl        <= n_lvl;
        r_row        <= n_row;
        r_bit        <= n_bit;
        r_ack        <= n_ack;
        r_reoi       <= n_reoi;
        r_reoi_vec   <= n_reoi_vec;
        r_cnt        <= n_cnt;
        r_scan_row   <= n_scan_row;
        r_o_ack      <= n_o_ack;
        r_o_pending  <= n_o_pending;
        r_o_reoi     <= n_o_reoi;
        r_o_reoi_vec <= n_o_reoi_vec;
        r_o_his      <= n_o_his;
    end

    assign o_valid              = r_o_valid;
    assign o_ack_vector         = r_o_ack;
    assign o_pending            = r_o_pending;
    assign o_remote_eoi         = r_o_reoi;
    assign o_remote_eoi_vector  = r_o_reoi_vec;
    assign o_highest_in_service = r_o_his;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |=> !r_o_valid)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    a_reoi_vec_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_reoi) |-> (r_o_reoi_vec == 8'd0))
        else $error("remote eoi vector set without remote eoi");

    a_pending_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_pending) |-> cfg.enable)
        else $error("pending reported while disabled");

    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == lip_pkg::ST_SCAN) || (r_state == lip_pkg::ST_DRAIN)) |-> !ram_we)
        else $error("row written during summary rescan");

endmodule

// ===== rtl/lip_ram.sv =====
module lip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lip_cfg.sv =====
module lip_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lip_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lip_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lip_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output lip_pkg::t_cfg                   o_cfg
);

    lip_pkg::t_cfg r_cfg;
    lip_pkg::t_cfg n_cfg;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (lip_pkg::t_reg'(paddr[2]))
                lip_pkg::REG_ENABLE:   n_cfg.enable   = pwdata[0];
                lip_pkg::REG_SPURIOUS: n_cfg.spurious = pwdata[7:0];
                default:               n_cfg          = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (lip_pkg::t_reg'(paddr[2]))
            lip_pkg::REG_ENABLE:   prdata = {{(lip_pkg::APB_DATA_W-1){1'b0}}, r_cfg.enable};
            lip_pkg::REG_SPURIOUS: prdata = {{(lip_pkg::APB_DATA_W-8){1'b0}}, r_cfg.spurious};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.spurious <= lip_pkg::SPURIOUS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/lip_scan.sv =====
module lip_scan #(
    parameter int VECTOR_COUNT = lip_pkg::VECTOR_COUNT_DEF,
    parameter int WORD_BITS    = lip_pkg::WORD_BITS_DEF,
    localparam int NWORDS      = (VECTOR_COUNT + WORD_BITS - 1) / WORD_BITS,
    localparam int ROW_W       = (NWORDS > 1) ? $clog2(NWORDS) : 1,
    localparam int BIT_W       = $clog2(WORD_BITS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lip_pkg::t_scan_ctl   i_ctl,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [WORD_BITS-1:0] i_req_word,
    input  logic [WORD_BITS-1:0] i_isv_word,
    output lip_pkg::t_summary    o_sum
);

    lip_pkg::t_summary r_sum;
    lip_pkg::t_summary n_sum;
    logic [7:0]        req_vec;
    logic [7:0]        isv_vec;

    function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (w[i]) begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

    assign req_vec = 8'(int'(i_row) * WORD_BITS + int'(top_bit(i_req_word)));
    assign isv_vec = 8'(int'(i_row) * WORD_BITS + int'(top_bit(i_isv_word)));

    // rows arrive from the top down, so the first nonzero word holds the maximum
    always_comb begin
        n_sum = r_sum;
        if (i_ctl.clear) begin
            n_sum.hr_found = 1'b0;
            n_sum.hs_found = 1'b0;
        end else begin
            if (i_ctl.load) begin
                if (!r_sum.hr_found && (i_req_word != '0)) begin
                    n_sum.hr_found = 1'b1;
                    n_sum.hr       = req_vec;
                end
                if (!r_sum.hs_found && (i_isv_word != '0)) begin
                    n_sum.hs_found = 1'b1;
                    n_sum.hs       = isv_vec;
                end
            end
            if (i_ctl.dlv_upd) begin
                if (!r_sum.hr_found || (i_ctl.dlv_vec > r_sum.hr)) begin
                    n_sum.hr_found = 1'b1;
                    n_sum.hr       = i_ctl.dlv_vec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum.hr_found <= 1'b0;
            r_sum.hs_found <= 1'b0;
            r_sum.hr       <= '0;
            r_sum.hs       <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
